/* rtl/core/rmdd_pkg.sv */
`default_nettype none

package rmdd_pkg;

    // Fixed-point formats
    localparam int RET_W   = 32;          // Q3.28 return
    localparam int FAC_W   = 33;          // Q4.28 factor 1 + r
    localparam int EQ_W    = 64;          // Q16.47 equity / peak
    localparam int DD_W    = 31;          // unsigned Q3.28 drawdown
    localparam int ACC_W   = 96;          // full equity * factor product
    localparam int REM_W   = 66;          // divider partial remainder
    localparam int STEP_W  = 5;
    localparam int DIV_STEPS = 31;        // 3 integer + 28 fraction bits

    localparam logic [EQ_W-1:0]  ONE_Q47     = 64'h0000_8000_0000_0000;
    localparam logic [FAC_W-1:0] ONE_Q28     = 33'h0_1000_0000;
    localparam logic [ACC_W-1:0] ROUND_HALF  = 96'h0_0800_0000;
    localparam logic [EQ_W-1:0]  EQ_MAX      = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [EQ_W-1:0]  EQ_MIN      = 64'h8000_0000_0000_0000;
    localparam logic [DD_W-1:0]  DD_MAX      = 31'h7FFF_FFFF;
    localparam logic [STEP_W-1:0] LAST_STEP  = STEP_W'(DIV_STEPS - 1);

    // Main sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_ROUND,
        ST_PEAK,
        ST_DIFF,
        ST_DIV_WAIT,
        ST_UPDATE
    } state_t;

    // Divider sequencer
    typedef enum logic [1:0] {
        DV_IDLE,
        DV_SAT,
        DV_STEP
    } div_state_t;

    // Divider response toward the main sequencer
    typedef struct packed {
        logic            done;
        logic [DD_W-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

/* rtl/core/rmdd_in_if.sv */
`default_nettype none

interface rmdd_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] period_return;
    logic        series_start;

    modport source (output valid, output period_return, output series_start, input ready);
    modport sink   (input valid, input period_return, input series_start, output ready);
endinterface

`default_nettype wire

/* rtl/core/rmdd_out_if.sv */
`default_nettype none

interface rmdd_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] max_drawdown_neg;

    modport source (output valid, output max_drawdown_neg, input ready);
    modport sink   (input valid, input max_drawdown_neg, output ready);
endinterface

`default_nettype wire

/* rtl/core/rmdd_divider.sv */
`default_nettype none

// Restoring divider: floor(diff * 2^28 / peak), saturated to 31 bits.
// One compare/subtract per cycle: one saturation check, then 31 quotient bits.
module rmdd_divider
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [rmdd_pkg::EQ_W-1:0]     diff,
    input  wire logic [rmdd_pkg::EQ_W-1:0]     peak,
    output rmdd_pkg::div_rsp_t                 rsp
);

    rmdd_pkg::div_state_t               state_reg, state_next;
    logic [rmdd_pkg::REM_W-1:0]         rem_reg, rem_next;
    logic [rmdd_pkg::EQ_W-1:0]          dvs_reg, dvs_next;
    logic [rmdd_pkg::DD_W-1:0]          quo_reg, quo_next;
    logic [rmdd_pkg::STEP_W-1:0]        cnt_reg, cnt_next;
    logic                               done_reg, done_next;

    logic [rmdd_pkg::REM_W:0]           opnd;
    logic [rmdd_pkg::REM_W+1:0]         sub;
    logic                               ge;
    logic [rmdd_pkg::REM_W-1:0]         rem_sub;

    // Shared compare/subtract: 8*peak for the saturation check, 4*peak per step
    always_comb
    begin
        if (state_reg == rmdd_pkg::DV_SAT)
            opnd = {dvs_reg, 3'b000};
        else
            opnd = {1'b0, dvs_reg, 2'b00};
        sub     = {2'b00, rem_reg} - {1'b0, opnd};
        ge      = ~sub[rmdd_pkg::REM_W+1];
        rem_sub = sub[rmdd_pkg::REM_W-1:0];
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rmdd_pkg::DV_IDLE:
                if (start)
                    state_next = rmdd_pkg::DV_SAT;
            rmdd_pkg::DV_SAT:
                state_next = ge ? rmdd_pkg::DV_IDLE : rmdd_pkg::DV_STEP;
            rmdd_pkg::DV_STEP:
                if (cnt_reg == rmdd_pkg::LAST_STEP)
                    state_next = rmdd_pkg::DV_IDLE;
            default:
                state_next = rmdd_pkg::DV_IDLE;
        endcase
    end

    // Datapath
    always_comb
    begin
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        case (state_reg)
            rmdd_pkg::DV_IDLE:
                if (start)
                begin
                    rem_next = {2'b00, diff};
                    dvs_next = peak;
                    quo_next = '0;
                    cnt_next = '0;
                end
            rmdd_pkg::DV_SAT:
                if (ge)
                begin
                    quo_next  = rmdd_pkg::DD_MAX;
                    done_next = 1'b1;
                end
            rmdd_pkg::DV_STEP:
            begin
                // remainder stays below 8*peak, so the shift never loses bits
                if (ge)
                    rem_next = {rem_sub[rmdd_pkg::REM_W-2:0], 1'b0};
                else
                    rem_next = {rem_reg[rmdd_pkg::REM_W-2:0], 1'b0};
                quo_next  = {quo_reg[rmdd_pkg::DD_W-2:0], ge};
                cnt_next  = cnt_reg + 1'b1;
                done_next = (cnt_reg == rmdd_pkg::LAST_STEP);
            end
            default:
                done_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rmdd_pkg::DV_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

/* rtl/core/running_max_drawdown_unit.sv */
`default_nettype none

// Channel   Dir  Payload                                   Handshake
// ret_in    in   period_return s32 Q3.28, series_start     valid/ready
// dd_out    out  max_drawdown_neg s32 Q3.28                valid/ready
//
// One transaction makes two passes through one shared
// 32x32 multiplier, rounding, peak and difference steps, then a restoring
// divider that resolves one quotient bit per cycle (31 bits) after a
// saturation check.
// Reset (rst_n, async, active low) sets equity and peak to 1.0 and the
// worst drawdown to zero. ret_in is ready only between transactions.
// A result waits in the output register; the next transaction may start
// meanwhile and holds before its update until the register is free.
module running_max_drawdown_unit
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    rmdd_in_if.sink     ret_in,
    rmdd_out_if.source  dd_out
);

    rmdd_pkg::state_t                  state_reg, state_next;

    logic [rmdd_pkg::EQ_W-1:0]         equity_reg, equity_next;
    logic [rmdd_pkg::EQ_W-1:0]         peak_reg, peak_next;
    logic [rmdd_pkg::DD_W-1:0]         worst_reg, worst_next;
    logic [rmdd_pkg::EQ_W-1:0]         mag_eq_reg, mag_eq_next;
    logic [31:0]                       mag_fac_reg, mag_fac_next;
    logic                              neg_reg, neg_next;
    logic [rmdd_pkg::ACC_W-1:0]        acc_reg, acc_next;
    logic                              out_valid_reg, out_valid_next;
    logic [31:0]                       out_data_reg, out_data_next;

    logic                              accept;
    logic                              out_free;
    logic [rmdd_pkg::EQ_W-1:0]         eq_start;
    logic [rmdd_pkg::FAC_W-1:0]        factor;
    logic [rmdd_pkg::FAC_W-1:0]        factor_abs;
    logic [31:0]                       mul_a;
    logic [63:0]                       mul_p;
    logic                              sat_hi;
    logic [rmdd_pkg::EQ_W-1:0]         mag_round;
    logic [rmdd_pkg::EQ_W-1:0]         eq_rounded;
    logic [rmdd_pkg::DD_W-1:0]         worst_new;
    logic                              div_start;
    rmdd_pkg::div_rsp_t                div_rsp;

    assign accept   = ret_in.valid && ret_in.ready;
    assign out_free = !out_valid_reg || dd_out.ready;

    // Input decode: equity source, factor 1 + r and magnitudes
    always_comb
    begin
        eq_start   = ret_in.series_start ? rmdd_pkg::ONE_Q47 : equity_reg;
        factor     = {ret_in.period_return[31], ret_in.period_return} + rmdd_pkg::ONE_Q28;
        factor_abs = factor[rmdd_pkg::FAC_W-1] ? (~factor + 1'b1) : factor;
    end

    // Shared multiplier: low word of equity first, high word second
    assign mul_a = (state_reg == rmdd_pkg::ST_MUL_LO) ? mag_eq_reg[31:0] : mag_eq_reg[63:32];
    assign mul_p = 64'(mul_a) * 64'(mag_fac_reg);

    // Round to Q16.47 and saturate
    always_comb
    begin
        sat_hi    = |acc_reg[95:92];
        mag_round = acc_reg[91:28];
        if (neg_reg)
        begin
            if (sat_hi || mag_round[63])
                eq_rounded = rmdd_pkg::EQ_MIN;
            else
                eq_rounded = ~mag_round + 1'b1;
        end
        else
        begin
            if (sat_hi || mag_round[63])
                eq_rounded = rmdd_pkg::EQ_MAX;
            else
                eq_rounded = mag_round;
        end
    end

    assign worst_new = (div_rsp.quotient > worst_reg) ? div_rsp.quotient : worst_reg;
    assign div_start = (state_reg == rmdd_pkg::ST_DIFF);

    rmdd_divider u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .diff  (peak_reg - equity_reg),
        .peak  (peak_reg),
        .rsp   (div_rsp)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rmdd_pkg::ST_IDLE:     if (accept) state_next = rmdd_pkg::ST_MUL_LO;
            rmdd_pkg::ST_MUL_LO:   state_next = rmdd_pkg::ST_MUL_HI;
            rmdd_pkg::ST_MUL_HI:   state_next = rmdd_pkg::ST_ROUND;
            rmdd_pkg::ST_ROUND:    state_next = rmdd_pkg::ST_PEAK;
            rmdd_pkg::ST_PEAK:     state_next = rmdd_pkg::ST_DIFF;
            rmdd_pkg::ST_DIFF:     state_next = rmdd_pkg::ST_DIV_WAIT;
            rmdd_pkg::ST_DIV_WAIT: if (div_rsp.done) state_next = rmdd_pkg::ST_UPDATE;
            rmdd_pkg::ST_UPDATE:   if (out_free) state_next = rmdd_pkg::ST_IDLE;
            default:               state_next = rmdd_pkg::ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        equity_next    = equity_reg;
        peak_next      = peak_reg;
        worst_next     = worst_reg;
        mag_eq_next    = mag_eq_reg;
        mag_fac_next   = mag_fac_reg;
        neg_next       = neg_reg;
        acc_next       = acc_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !dd_out.ready;
        case (state_reg)
            rmdd_pkg::ST_IDLE:
                if (accept)
                begin
                    if (ret_in.series_start)
                    begin
                        peak_next  = rmdd_pkg::ONE_Q47;
                        worst_next = '0;
                    end
                    mag_eq_next  = eq_start[63] ? (~eq_start + 1'b1) : eq_start;
                    mag_fac_next = factor_abs[31:0];
                    neg_next     = eq_start[63] ^ factor[rmdd_pkg::FAC_W-1];
                end
            rmdd_pkg::ST_MUL_LO:
                acc_next = {32'd0, mul_p} + rmdd_pkg::ROUND_HALF;
            rmdd_pkg::ST_MUL_HI:
                acc_next = {({32'd0, acc_reg[63:32]} + mul_p), acc_reg[31:0]};
            rmdd_pkg::ST_ROUND:
                equity_next = eq_rounded;
            rmdd_pkg::ST_PEAK:
                if ($signed(equity_reg) > $signed(peak_reg))
                    peak_next = equity_reg;
            rmdd_pkg::ST_UPDATE:
                if (out_free)
                begin
                    worst_next     = worst_new;
                    out_data_next  = 32'd0 - {1'b0, worst_new};
                    out_valid_next = 1'b1;
                end
            default:
                out_valid_next = out_valid_reg && !dd_out.ready;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rmdd_pkg::ST_IDLE;
            equity_reg    <= rmdd_pkg::ONE_Q47;
            peak_reg      <= rmdd_pkg::ONE_Q47;
            worst_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            equity_reg    <= equity_next;
            peak_reg      <= peak_next;
            worst_reg     <= worst_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_eq_reg   <= mag_eq_next;
        mag_fac_reg  <= mag_fac_next;
        neg_reg      <= neg_next;
        acc_reg      <= acc_next;
        out_data_reg <= out_data_next;
    end

    assign ret_in.ready            = (state_reg == rmdd_pkg::ST_IDLE);
    assign dd_out.valid            = out_valid_reg;
    assign dd_out.max_drawdown_neg = out_data_reg;

    // Peak never drops below 1.0, so the divisor is never zero
    a_peak_floor: assert property (@(posedge clk) disable iff (!rst_n)
        !peak_reg[63] && (peak_reg >= rmdd_pkg::ONE_Q47))
        else $error("peak below 1.0");

    // Worst drawdown only grows, except on a series restart
    a_worst_mono: assert property (@(posedge clk) disable iff (!rst_n)
        !(accept && ret_in.series_start) |=> (worst_reg >= $past(worst_reg)))
        else $error("worst drawdown decreased");

    // Divider completes only while the sequencer waits for it
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == rmdd_pkg::ST_DIV_WAIT))
        else $error("divider result outside wait state");

    // Published result is never positive
    a_out_sign: assert property (@(posedge clk) disable iff (!rst_n)
        dd_out.valid |-> (out_data_reg[31] || (out_data_reg == 32'd0)))
        else $error("positive drawdown output");

endmodule

`default_nettype wire

/* bench/running_max_drawdown_unit_tb.sv */
module running_max_drawdown_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1450;
    localparam int REPORT_LIMIT = 10;
    localparam int DRAIN_LIMIT  = 50000;
    localparam int SETTLE_CYCLES = 200;
    localparam int HOLD_AFTER   = 200;     // transactions before the long hold-off
    localparam int HOLD_CYCLES  = 400;

    // Notable returns, Q3.28
    localparam logic [31:0] RET_ZERO     = 32'h0000_0000;
    localparam logic [31:0] RET_MAX      = 32'h7FFF_FFFF;   // factor just under 9
    localparam logic [31:0] RET_MIN      = 32'h8000_0000;   // factor -7
    localparam logic [31:0] RET_WIPEOUT  = 32'hF000_0000;   // factor exactly 0
    localparam logic [31:0] RET_NEAR_OUT = 32'hF000_0001;   // factor 2^-28
    localparam logic [31:0] RET_HALF_UP  = 32'h0800_0000;
    localparam logic [31:0] RET_HALF_DN  = 32'hF800_0000;
    localparam logic [31:0] RET_TICK_UP  = 32'h0010_0000;
    localparam logic [31:0] RET_TICK_DN  = 32'hFFF0_0000;

    typedef enum int {
        SINK_OPEN,
        SINK_COIN,
        SINK_SPARSE,
        SINK_EVERY_THIRD
    } sink_mode_t;

    // Drawdown predictor plus store of expected outputs
    class drawdown_tracker;
        localparam logic signed [63:0] EQ_ONE = 64'sh0000_8000_0000_0000;
        localparam logic signed [63:0] EQ_TOP = 64'sh7FFF_FFFF_FFFF_FFFF;
        localparam logic signed [63:0] EQ_BOT = 64'sh8000_0000_0000_0000;
        localparam logic [30:0] DD_CEIL = 31'h7FFF_FFFF;

        logic signed [63:0] equity_q47;
        logic signed [63:0] peak_q47;
        logic [30:0]        worst_dd;
        logic [31:0]        pending_dd[$];
        int                 failures;
        int                 items_seen;

        function new();
            restart_series();
            failures = 0;
            items_seen = 0;
        endfunction

        function void restart_series();
            equity_q47 = EQ_ONE;
            peak_q47 = EQ_ONE;
            worst_dd = '0;
        endfunction

        function void report(string msg);
            failures++;
            if (failures <= REPORT_LIMIT)
                $display("%0t ERROR: %s", $realtime, msg);
        endfunction

        // Apply one period return and queue the resulting output
        function void note_return(logic [31:0] ret_bits, logic start);
            logic signed [32:0] factor;
            logic               negative;
            logic [63:0]        eq_mag;
            logic [32:0]        fac_abs;
            logic [127:0]       product;
            logic [127:0]       mag;
            logic [63:0]        diff;
            logic [127:0]       quot;
            logic [30:0]        dd;

            items_seen++;
            if (start)
                restart_series();

            factor = $signed({ret_bits[31], ret_bits}) + 33'sh0_1000_0000;
            negative = equity_q47[63] ^ factor[32];
            eq_mag = equity_q47[63] ? 64'(-equity_q47) : 64'(equity_q47);
            fac_abs = factor[32] ? 33'(-factor) : 33'(factor);

            // full product, round magnitude half away from zero, back to Q16.47
            product = {64'd0, eq_mag} * {96'd0, fac_abs[31:0]} + 128'h800_0000;
            mag = product >> 28;
            if (negative)
                equity_q47 = (mag >= (128'd1 << 63)) ? EQ_BOT : -$signed(mag[63:0]);
            else
                equity_q47 = (mag > 128'(EQ_TOP)) ? EQ_TOP : $signed(mag[63:0]);

            if (equity_q47 > peak_q47)
                peak_q47 = equity_q47;

            // peak never drops below 1.0, so unsigned division is safe
            diff = 64'(peak_q47) - 64'(equity_q47);
            quot = ({64'd0, diff} << 28) / {64'd0, 64'(peak_q47)};
            dd = (quot >= (128'd1 << 31)) ? DD_CEIL : quot[30:0];
            if (dd > worst_dd)
                worst_dd = dd;

            pending_dd.push_back(32'd0 - {1'b0, worst_dd});
        endfunction

        function void check_drawdown(logic [31:0] seen);
            logic [31:0] want;

            if (pending_dd.size() == 0)
            begin
                report($sformatf("output %h with no transaction pending", seen));
                return;
            end
            want = pending_dd.pop_front();
            if (seen !== want)
                report($sformatf("max_drawdown_neg expected %h actual %h", want, seen));
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic hold_off = 1'b0;

    rmdd_in_if  ret_in();
    rmdd_out_if dd_out();

    drawdown_tracker tracker = new();

    int burst_left = 0;

    sink_mode_t sink_mode = SINK_OPEN;
    int         sink_left = 0;
    int         sink_phase = 0;

    running_max_drawdown_unit dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ret_in (ret_in),
        .dd_out (dd_out)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Monitors: sample handshakes at the edge
    always @(posedge clk)
    begin
        if (rst_n && ret_in.valid && ret_in.ready)
            tracker.note_return(ret_in.period_return, ret_in.series_start);
        if (rst_n && dd_out.valid && dd_out.ready)
            tracker.check_drawdown(dd_out.max_drawdown_neg);
    end

    // Output side stall pattern, switching modes every so often
    always @(posedge clk)
    begin
        logic open_now;

        if (sink_left == 0)
        begin
            sink_mode = sink_mode_t'($urandom_range(SINK_EVERY_THIRD, SINK_OPEN));
            sink_left = $urandom_range(300, 30);
        end
        else
            sink_left--;
        sink_phase = (sink_phase + 1) % 3;

        case (sink_mode)
            SINK_OPEN:        open_now = 1'b1;
            SINK_COIN:        open_now = ($urandom_range(1, 0) == 1);
            SINK_SPARSE:      open_now = ($urandom_range(9, 0) == 0);
            SINK_EVERY_THIRD: open_now = (sink_phase == 0);
            default:          open_now = 1'b1;
        endcase
        dd_out.ready <= rst_n && !hold_off && open_now;
    end

    // One long hold-off so the block backs up into its input
    initial
    begin
        while (tracker.items_seen < HOLD_AFTER)
            @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Offer one transaction, pacing the sender in bursts with gaps between
    task automatic send_return(logic [31:0] ret, logic start);
        int gap;

        if (burst_left == 0)
        begin
            burst_left = $urandom_range(24, 1);
            gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1);
            if (gap != 0)
            begin
                ret_in.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;

        ret_in.valid <= 1'b1;
        ret_in.period_return <= ret;
        ret_in.series_start <= start;
        do
            @(posedge clk);
        while (!ret_in.ready);
    endtask

    // Mostly market-like returns, with some wild ones and exact specials
    function automatic logic [31:0] draw_return();
        int unsigned pick;

        pick = $urandom_range(99, 0);
        if (pick < 60)
            return 32'(int'($urandom_range(1 << 23, 0)) - (1 << 22));
        if (pick < 80)
            return 32'(int'($urandom_range(1 << 27, 0)) - (1 << 26));
        if (pick < 92)
            return $urandom;
        case ($urandom_range(4, 0))
            0:       return RET_ZERO;
            1:       return RET_WIPEOUT;
            2:       return RET_MAX;
            3:       return RET_MIN;
            default: return RET_NEAR_OUT;
        endcase
    endfunction

    initial
    begin
        int sent;
        int run_len;
        int drain;

        ret_in.valid = 1'b0;
        ret_in.period_return = '0;
        ret_in.series_start = 1'b0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: flat start, big gain then wipeout to zero equity
        send_return(RET_ZERO, 1'b1);
        send_return(RET_MAX, 1'b0);
        send_return(RET_WIPEOUT, 1'b0);
        // equity climbs to the top of its range and saturates
        send_return(RET_ZERO, 1'b1);
        repeat (6) send_return(RET_MAX, 1'b0);
        // negative factor on saturated equity: bottom saturation, then top saturation again
        send_return(RET_MIN, 1'b0);
        send_return(RET_MIN, 1'b0);
        // negative equity from a fresh series; zero product with a negative operand
        send_return(RET_MIN, 1'b1);
        send_return(RET_WIPEOUT, 1'b0);
        // nearly total loss
        send_return(RET_NEAR_OUT, 1'b1);
        // ordinary moves and a restart carrying its own return
        send_return(RET_TICK_UP, 1'b1);
        send_return(RET_TICK_DN, 1'b0);
        send_return(RET_HALF_UP, 1'b0);
        send_return(RET_HALF_DN, 1'b0);
        send_return(RET_HALF_DN, 1'b0);
        send_return(RET_MAX, 1'b1);
        send_return(RET_HALF_DN, 1'b0);
        send_return(RET_MIN, 1'b0);
        send_return(32'hFFFF_FFFF, 1'b0);

        // Random: series of random length, with some stray restarts
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            run_len = $urandom_range(60, 5);
            for (int j = 0; j < run_len && sent < RANDOM_ITEMS; j++)
            begin
                send_return(draw_return(), j == 0 || $urandom_range(39, 0) == 0);
                sent++;
            end
        end
        ret_in.valid <= 1'b0;
        // let the monitor log the last accepted transaction
        @(posedge clk);

        // Drain, then let the pipeline settle
        drain = 0;
        while (tracker.pending_dd.size() != 0 && drain < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (tracker.pending_dd.size() != 0)
            tracker.report($sformatf("%0d outputs never arrived", tracker.pending_dd.size()));

        if (tracker.failures == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog
    initial
    begin
        #6_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

/* running_max_drawdown_unit.f */
rtl/core/rmdd_pkg.sv
rtl/core/rmdd_in_if.sv
rtl/core/rmdd_out_if.sv
rtl/core/rmdd_divider.sv
rtl/core/running_max_drawdown_unit.sv
bench/running_max_drawdown_unit_tb.sv
